FILE: rtl/assert_macros.svh
// Assertion helpers shared by the console RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Same-cycle implication
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  // Default grid geometry
  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int COLOUR_W = 8;
  localparam int CFG_IDX_W = 1;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_PUT_CHAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BACKSPACE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PROMPT    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_READ_CELL = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PROMPT_COLOUR = 1'b1;

  // Register reset values
  localparam logic [COLOUR_W-1:0] TEXT_COLOUR_RESET   = 8'h0D;
  localparam logic [COLOUR_W-1:0] PROMPT_COLOUR_RESET = 8'h0C;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   character;
    logic [ADDR_W-1:0]   cell_address;
  } in_req_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   cell_value;
    logic                screen_cleared;
  } out_req_t;

  // Cursor move commands, at most one per cycle
  typedef struct packed {
    logic advance;
    logic newline;
    logic back;
  } cur_cmd_t;

endpackage

FILE: rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tcw_cursor.sv
`include "assert_macros.svh"

module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tcw_pkg::cur_cmd_t                cmd,
  output logic [$clog2(ROWS*COLUMNS)-1:0]  pos,
  output logic [$clog2(ROWS*COLUMNS)-1:0]  pos_next,
  output logic                             wrap
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic          last_col;
  logic          last_row;

  assign last_col = (col == CW'(COLUMNS - 1));
  assign last_row = (row == RW'(ROWS - 1));

  // Next cursor; linear position kept alongside row and column
  always_comb begin
    row_next = row;
    col_next = col;
    pos_next = pos;
    wrap     = 1'b0;
    if (cmd.advance) begin
      if (last_col && last_row) begin
        wrap     = 1'b1;
        row_next = '0;
        col_next = '0;
        pos_next = '0;
      end else if (last_col) begin
        row_next = row + RW'(1);
        col_next = '0;
        pos_next = pos + AW'(1);
      end else begin
        col_next = col + CW'(1);
        pos_next = pos + AW'(1);
      end
    end else if (cmd.newline) begin
      if (last_row) begin
        wrap     = 1'b1;
        row_next = '0;
        col_next = '0;
        pos_next = '0;
      end else begin
        row_next = row + RW'(1);
        col_next = '0;
        pos_next = pos + AW'(COLUMNS) - AW'(col);
      end
    end else if (cmd.back) begin
      pos_next = pos - AW'(1);
      if (col == '0) begin
        col_next = CW'(COLUMNS - 1);
        row_next = row - RW'(1);
      end else begin
        col_next = col - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      pos <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
      pos <= pos_next;
    end
  end

  `TCW_ASSERT(a_pos_matches_rc, (32'(pos) == 32'(row) * 32'(COLUMNS) + 32'(col)), "linear position out of step with row and column")
  `TCW_ASSERT(a_pos_in_grid, (32'(pos) < 32'(CELLS)), "cursor beyond grid")
  `TCW_ASSERT(a_single_cmd, $onehot0(cmd), "more than one cursor command")

endmodule

FILE: rtl/text_console_writer.sv
// Text console engine: a ROWS x COLUMNS grid of 16-bit cells (attribute byte over
// character byte) held in one synchronous RAM, plus a cursor. Each request returns
// one result with the cursor position after it. Put character, newline and prompt
// marker complete from the idle state; backspace and cell read pass through a read
// state, since they wait on the RAM's registered read. A backspace is refused when
// the cell two places back holds the prompt marker. After reset, and after any
// request that runs past the bottom row, the engine sweeps the RAM to spaces in
// the text colour, one cell per cycle, and holds off input meanwhile; the result
// of the request that caused the wrap is delivered without waiting for the sweep.
// Colour registers may be written at any time the engine has no request in flight.
`include "assert_macros.svh"

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tcw_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tcw_pkg::out_req_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::COLOUR_W-1:0]    cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state;

  logic [tcw_pkg::COLOUR_W-1:0] text_colour;
  logic [tcw_pkg::COLOUR_W-1:0] prompt_colour;
  logic [AW-1:0]                clr_addr;
  logic [tcw_pkg::CELL_W-1:0]   blank;
  logic [tcw_pkg::OPCODE_W-1:0] op_q;
  logic                         range_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         finish;
  logic                         addr_in_range;
  logic                         pos_ge2;
  logic [tcw_pkg::CELL_W-1:0]   marker;
  logic [tcw_pkg::CELL_W-1:0]   text_blank;
  logic [tcw_pkg::CELL_W-1:0]   res_value;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [tcw_pkg::CELL_W-1:0]   wdata;
  logic                         re;
  logic [AW-1:0]                raddr;
  logic [tcw_pkg::CELL_W-1:0]   rdata;

  tcw_pkg::cur_cmd_t            cmd;
  logic [AW-1:0]                pos;
  logic [AW-1:0]                pos_next;
  logic                         wrap;

  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || !out_stall;
  assign in_stall      = !((state == ST_IDLE) && out_free);
  assign in_accept     = in_valid && !in_stall;
  assign addr_in_range = (32'(in_data.cell_address) < 32'(CELLS));
  assign pos_ge2       = (32'(pos) >= 32'd2);
  assign marker        = {prompt_colour, tcw_pkg::CH_COLON};
  assign text_blank    = {text_colour, tcw_pkg::CH_SPACE};

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .pos      (pos),
    .pos_next (pos_next),
    .wrap     (wrap)
  );

  // Request decode, RAM port control and cursor commands
  always_comb begin
    cmd       = '0;
    we        = 1'b0;
    waddr     = pos;
    wdata     = text_blank;
    re        = 1'b0;
    raddr     = pos - AW'(2);
    finish    = 1'b0;
    res_value = '0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = blank;
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data.opcode)
            tcw_pkg::OP_PUT_CHAR: begin
              finish = 1'b1;
              if (in_data.character == tcw_pkg::CH_NEWLINE) begin
                cmd.newline = 1'b1;
              end else begin
                we          = 1'b1;
                wdata       = {text_colour, in_data.character};
                cmd.advance = 1'b1;
              end
            end
            tcw_pkg::OP_PROMPT: begin
              finish      = 1'b1;
              we          = 1'b1;
              wdata       = marker;
              cmd.advance = 1'b1;
            end
            tcw_pkg::OP_BACKSPACE: begin
              // fetch the cell two back for the prompt check
              re = pos_ge2;
            end
            tcw_pkg::OP_READ_CELL: begin
              re    = addr_in_range;
              raddr = AW'(in_data.cell_address);
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          finish = 1'b1;
          if (op_q == tcw_pkg::OP_READ_CELL) begin
            res_value = range_q ? rdata : '0;
          end else if ((pos != '0) && !(pos_ge2 && (rdata == marker))) begin
            we       = 1'b1;
            waddr    = pos - AW'(1);
            wdata    = text_blank;
            cmd.back = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // State, registers and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      blank         <= {tcw_pkg::TEXT_COLOUR_RESET, tcw_pkg::CH_SPACE};
      text_colour   <= tcw_pkg::TEXT_COLOUR_RESET;
      prompt_colour <= tcw_pkg::PROMPT_COLOUR_RESET;
      op_q          <= tcw_pkg::OP_PUT_CHAR;
      range_q       <= 1'b0;
      out_valid     <= 1'b0;
      out_data      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tcw_pkg::REG_TEXT_COLOUR:   text_colour   <= cfg_data;
          tcw_pkg::REG_PROMPT_COLOUR: prompt_colour <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            op_q    <= in_data.opcode;
            range_q <= addr_in_range;
            if (!finish) begin
              state <= ST_READ;
            end else if (wrap) begin
              state    <= ST_CLEAR;
              clr_addr <= '0;
              blank    <= text_blank;
            end
          end
        end
        ST_READ: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (finish) begin
        out_valid                <= 1'b1;
        out_data.cursor_position <= tcw_pkg::CURSOR_W'(pos_next);
        out_data.cell_value      <= res_value;
        out_data.screen_cleared  <= wrap;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TCW_ASSERT_IMPL(a_clear_holds_input, state == ST_CLEAR, in_stall, "input taken during clear sweep")
  `TCW_ASSERT_IMPL(a_cleared_homes, out_valid && out_data.screen_cleared, out_data.cursor_position == '0, "clear result with cursor not home")
  `TCW_ASSERT(a_wrap_starts_clear, (finish && wrap) |=> (state == ST_CLEAR), "wrap did not start a clear sweep")
  `TCW_ASSERT_IMPL(a_no_write_on_read, (state == ST_READ) && (op_q == tcw_pkg::OP_READ_CELL), !we, "cell read wrote the grid")

endmodule
